// ===== src/rcsv_pkg.sv =====
// ----------------------------------------------------------------------------
// rcsv_pkg
// Types and constants shared by the stick-to-velocity mapper pipeline.
// ----------------------------------------------------------------------------
package rcsv_pkg;

   localparam int NUM_AXES   = 3;
   localparam int NUM_STAGES = 7;

   // Stick geometry
   localparam logic [15:0]        STICK_LOW     = 16'd900;
   localparam logic [15:0]        STICK_HIGH    = 16'd2100;
   localparam logic signed [16:0] STICK_CENTER  = 17'sd1500;
   localparam logic signed [16:0] STICK_SPAN    = 17'sd500;
   localparam logic [15:0]        GEAR_LOW_POS  = 16'd1000;
   localparam logic [15:0]        GEAR_HIGH_POS = 16'd2000;

   // Scaling: s = round(d * limit * gain / (500 * 4096)), ties away from zero.
   // The divisor is split into a shift by 14 and a divide by 125.
   localparam logic [41:0] ROUND_BIAS = 42'd1024000;
   localparam logic [25:0] RECIP_125  = 26'd34359738;   // floor(2^32 / 125)
   localparam logic [26:0] DIV_125    = 27'd125;

   typedef enum logic [2:0] {
      REG_DEADBAND    = 3'd0,
      REG_SWITCH_TOL  = 3'd1,
      REG_ENABLE_THR  = 3'd2,
      REG_FAST_LIMITS = 3'd3,
      REG_MID_LIMITS  = 3'd4,
      REG_SLOW_LIMITS = 3'd5,
      REG_AXIS_GAINS  = 3'd6,
      REG_FINAL_LIMIT = 3'd7
   } reg_index_type;

   typedef enum logic [1:0] {
      STATUS_LINK_LOST = 2'd0,
      STATUS_KNOB_LOCK = 2'd1,
      STATUS_DRIVING   = 2'd2
   } drive_status_type;

   typedef struct packed {
      logic        link_valid;
      logic [15:0] forward_stick;
      logic [15:0] side_stick;
      logic [15:0] turn_stick;
      logic [15:0] gear_switch;
      logic [15:0] enable_knob;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] yaw_rate;
      logic [1:0]         drive_status;
   } rsp_payload_type;

   typedef struct packed {
      logic [9:0]  deadband;
      logic [9:0]  switch_tol;
      logic [15:0] enable_thr;
      logic [47:0] fast_limits;
      logic [47:0] mid_limits;
      logic [47:0] slow_limits;
      logic [47:0] axis_gains;
      logic [47:0] final_limits;
   } cfg_type;

   // Per-axis operands leaving the decode stage
   typedef struct packed {
      logic signed [10:0] offset;
      logic signed [15:0] limit;
      logic [15:0]        gain;
      logic signed [15:0] out_cap;
   } axis_op_type;

endpackage

// ===== src/rcsv_frontend.sv =====
// ----------------------------------------------------------------------------
// rcsv_frontend
// Decode stage: link and knob status, gear selection, stick offset with
// range check, deadband and span clamp. Registers per-axis operands.
// ----------------------------------------------------------------------------
module rcsv_frontend
   import rcsv_pkg::*;
(
   input  logic                             clock,
   input  logic                             load,
   input  req_payload_type                  req_data,
   input  cfg_type                          cfg,
   output drive_status_type                 status,
   output axis_op_type [NUM_AXES-1:0]       ops
);

   drive_status_type             status_ff, status_in;
   axis_op_type [NUM_AXES-1:0]   ops_ff, ops_in;
   logic [47:0]                  gear_limits;
   logic [15:0]                  sticks [NUM_AXES];

   function automatic logic near_pos(input logic [15:0] v, input logic [15:0] pos,
                                     input logic [9:0] tol);
      logic [15:0] delta;
      delta = (v > pos) ? (v - pos) : (pos - v);
      return delta <= {6'd0, tol};
   endfunction

   function automatic logic signed [10:0] stick_offset(input logic [15:0] stick,
                                                       input logic [9:0] band);
      logic signed [16:0] raw;
      logic [16:0]        mag;
      logic signed [10:0] res;
      raw = $signed({1'b0, stick}) - STICK_CENTER;
      mag = raw[16] ? 17'(-raw) : 17'(raw);
      res = '0;
      if (stick >= STICK_LOW && stick <= STICK_HIGH && mag > {7'd0, band}) begin
         if (raw > STICK_SPAN) begin
            res = 11'(STICK_SPAN);
         end else if (raw < -STICK_SPAN) begin
            res = 11'(-STICK_SPAN);
         end else begin
            res = raw[10:0];
         end
      end
      return res;
   endfunction

   assign sticks[0] = req_data.forward_stick;
   assign sticks[1] = req_data.side_stick;
   assign sticks[2] = req_data.turn_stick;

   always_comb begin
      if (near_pos(req_data.gear_switch, GEAR_LOW_POS, cfg.switch_tol)) begin
         gear_limits = cfg.fast_limits;
      end else if (near_pos(req_data.gear_switch, GEAR_HIGH_POS, cfg.switch_tol)) begin
         gear_limits = cfg.slow_limits;
      end else begin
         gear_limits = cfg.mid_limits;
      end
   end

   always_comb begin
      if (!req_data.link_valid) begin
         status_in = STATUS_LINK_LOST;
      end else if (req_data.enable_knob > cfg.enable_thr) begin
         status_in = STATUS_KNOB_LOCK;
      end else begin
         status_in = STATUS_DRIVING;
      end
      for (int a = 0; a < NUM_AXES; a++) begin
         if (status_in == STATUS_DRIVING) begin
            ops_in[a].offset  = stick_offset(sticks[a], cfg.deadband);
            ops_in[a].limit   = $signed(gear_limits[16*a +: 16]);
            ops_in[a].gain    = cfg.axis_gains[16*a +: 16];
            ops_in[a].out_cap = $signed(cfg.final_limits[16*a +: 16]);
         end else begin
            // zero every operand so both clamps pass zero through
            ops_in[a] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         status_ff <= status_in;
         ops_ff    <= ops_in;
      end
   end

   assign status = status_ff;
   assign ops    = ops_ff;

endmodule

// ===== src/rcsv_axis.sv =====
// ----------------------------------------------------------------------------
// rcsv_axis
// Per-axis scaling pipeline: two multiplies, rounding shift, reciprocal
// divide by 125 with correction, gear and final clamps, negation.
// ----------------------------------------------------------------------------
module rcsv_axis
   import rcsv_pkg::*;
(
   input  logic                     clock,
   input  logic [NUM_STAGES-2:0]    stage_adv,   // enables of stages 1..6
   input  axis_op_type              op,
   output logic signed [15:0]       vel
);

   // stage 1: offset * limit
   logic signed [26:0] p1_ff, p1_in;
   logic [15:0]        gain1_ff;
   logic signed [15:0] lim1_ff, fin1_ff;
   // stage 2: * gain
   logic signed [41:0] p2_ff, p2_in;
   logic signed [15:0] lim2_ff, fin2_ff;
   // stage 3: magnitude, rounding bias, shift by 14
   logic [41:0]        mag3, sum3;
   logic [25:0]        q3_ff, q3_in;
   logic               neg3_ff;
   logic signed [15:0] lim3_ff, fin3_ff;
   // stage 4: reciprocal estimate
   logic [51:0]        prod4;
   logic [19:0]        est4_ff, est4_in;
   logic [25:0]        q4_ff;
   logic               neg4_ff;
   logic signed [15:0] lim4_ff, fin4_ff;
   // stage 5: correction and sign
   logic [26:0]        back5, rem5;
   logic [19:0]        quot5;
   logic signed [21:0] s5_ff, s5_in;
   logic signed [15:0] lim5_ff, fin5_ff;
   // stage 6: clamps, negate, saturate
   logic signed [21:0] lim6, nlim6, fin6, nfin6, c1, c2, n6;
   logic signed [15:0] vel_ff, vel_in;

   assign p1_in = 27'(op.offset) * 27'(op.limit);

   always_ff @(posedge clock) begin
      if (stage_adv[0]) begin
         p1_ff    <= p1_in;
         gain1_ff <= op.gain;
         lim1_ff  <= op.limit;
         fin1_ff  <= op.out_cap;
      end
   end

   assign p2_in = 42'(p1_ff) * 42'($signed({1'b0, gain1_ff}));

   always_ff @(posedge clock) begin
      if (stage_adv[1]) begin
         p2_ff   <= p2_in;
         lim2_ff <= lim1_ff;
         fin2_ff <= fin1_ff;
      end
   end

   assign mag3  = p2_ff[41] ? 42'(-p2_ff) : 42'(p2_ff);
   assign sum3  = mag3 + ROUND_BIAS;
   assign q3_in = sum3[39:14];

   always_ff @(posedge clock) begin
      if (stage_adv[2]) begin
         q3_ff   <= q3_in;
         neg3_ff <= p2_ff[41];
         lim3_ff <= lim2_ff;
         fin3_ff <= fin2_ff;
      end
   end

   // estimate is exact or one short
   assign prod4   = 52'(q3_ff) * 52'(RECIP_125);
   assign est4_in = prod4[51:32];

   always_ff @(posedge clock) begin
      if (stage_adv[3]) begin
         est4_ff <= est4_in;
         q4_ff   <= q3_ff;
         neg4_ff <= neg3_ff;
         lim4_ff <= lim3_ff;
         fin4_ff <= fin3_ff;
      end
   end

   assign back5 = 27'(est4_ff) * DIV_125;
   assign rem5  = 27'(q4_ff) - back5;
   assign quot5 = (rem5 >= DIV_125) ? (est4_ff + 20'd1) : est4_ff;
   assign s5_in = neg4_ff ? -$signed(22'(quot5)) : $signed(22'(quot5));

   always_ff @(posedge clock) begin
      if (stage_adv[4]) begin
         s5_ff   <= s5_in;
         lim5_ff <= lim4_ff;
         fin5_ff <= fin4_ff;
      end
   end

   // upper bound tested first, then lower, even when the bounds are swapped
   always_comb begin
      lim6  = 22'(lim5_ff);
      nlim6 = -lim6;
      fin6  = 22'(fin5_ff);
      nfin6 = -fin6;
      if (s5_ff > lim6) begin
         c1 = lim6;
      end else if (s5_ff < nlim6) begin
         c1 = nlim6;
      end else begin
         c1 = s5_ff;
      end
      if (c1 > fin6) begin
         c2 = fin6;
      end else if (c1 < nfin6) begin
         c2 = nfin6;
      end else begin
         c2 = c1;
      end
      n6 = -c2;
      if (n6 > 22'sd32767) begin
         vel_in = 16'sd32767;
      end else if (n6 < -22'sd32768) begin
         vel_in = -16'sd32768;
      end else begin
         vel_in = n6[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (stage_adv[5]) begin
         vel_ff <= vel_in;
      end
   end

   assign vel = vel_ff;

endmodule

// ===== src/rc_stick_to_velocity_mapper.sv =====
// ----------------------------------------------------------------------------
// rc_stick_to_velocity_mapper
// Maps one decoded remote-control frame to a Q8.8 chassis velocity command.
//
//   channel   ports               direction   payload
//   request   req_valid/req_stall in          req_payload_type (one frame)
//   response  rsp_valid/rsp_stall out         rsp_payload_type (vx, vy, wz,
//                                                                status)
//   config    csr_* (APB style)   in/out      8 registers, 64-bit data,
//                                             byte address 8 * index
//
// One frame per cycle sustained while the response is not stalled; each frame
// passes through the pipeline stages in order (decode, two multiplies, rounding
// shift, reciprocal divide, correction, clamp/negate into the output register).
// Each stage holds only while the stage after it is full and held, so a
// stalled response blocks input only once every stage is occupied; bubbles
// close up. Reset clears stage valid bits and loads register defaults.
// ----------------------------------------------------------------------------
module rc_stick_to_velocity_mapper
   import rcsv_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_data,
   input  logic            csr_psel,
   input  logic            csr_penable,
   input  logic            csr_pwrite,
   input  logic [5:0]      csr_paddr,
   input  logic [63:0]     csr_pwdata,
   output logic [63:0]     csr_prdata,
   output logic            csr_pready
);

   cfg_type                    cfg_ff, cfg_in;
   reg_index_type              csr_index;
   logic                       csr_write;

   logic [NUM_STAGES-1:0]      valid_ff, valid_in;
   logic [NUM_STAGES-1:0]      adv;
   drive_status_type           status0;
   drive_status_type           status_ff [1:NUM_STAGES-1];
   axis_op_type [NUM_AXES-1:0] ops0;
   logic signed [15:0]         vel [NUM_AXES];

   // ---------------- configuration registers ----------------
   assign csr_index  = reg_index_type'(csr_paddr[5:3]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            REG_DEADBAND:    cfg_in.deadband     = csr_pwdata[9:0];
            REG_SWITCH_TOL:  cfg_in.switch_tol   = csr_pwdata[9:0];
            REG_ENABLE_THR:  cfg_in.enable_thr   = csr_pwdata[15:0];
            REG_FAST_LIMITS: cfg_in.fast_limits  = csr_pwdata[47:0];
            REG_MID_LIMITS:  cfg_in.mid_limits   = csr_pwdata[47:0];
            REG_SLOW_LIMITS: cfg_in.slow_limits  = csr_pwdata[47:0];
            REG_AXIS_GAINS:  cfg_in.axis_gains   = csr_pwdata[47:0];
            REG_FINAL_LIMIT: cfg_in.final_limits = csr_pwdata[47:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.deadband     <= 10'd10;
         cfg_ff.switch_tol   <= 10'd100;
         cfg_ff.enable_thr   <= 16'd1200;
         cfg_ff.fast_limits  <= '0;
         cfg_ff.mid_limits   <= '0;
         cfg_ff.slow_limits  <= '0;
         cfg_ff.axis_gains   <= '0;
         cfg_ff.final_limits <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_DEADBAND:    csr_prdata = {54'd0, cfg_ff.deadband};
         REG_SWITCH_TOL:  csr_prdata = {54'd0, cfg_ff.switch_tol};
         REG_ENABLE_THR:  csr_prdata = {48'd0, cfg_ff.enable_thr};
         REG_FAST_LIMITS: csr_prdata = {16'd0, cfg_ff.fast_limits};
         REG_MID_LIMITS:  csr_prdata = {16'd0, cfg_ff.mid_limits};
         REG_SLOW_LIMITS: csr_prdata = {16'd0, cfg_ff.slow_limits};
         REG_AXIS_GAINS:  csr_prdata = {16'd0, cfg_ff.axis_gains};
         REG_FINAL_LIMIT: csr_prdata = {16'd0, cfg_ff.final_limits};
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // a stage advances when empty or when the stage after it advances
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
      for (int i = NUM_STAGES-2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? req_valid : valid_ff[0];
      for (int i = 1; i < NUM_STAGES; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !adv[0];
   assign rsp_valid = valid_ff[NUM_STAGES-1];

   // ---------------- datapath ----------------
   rcsv_frontend u_frontend (
      .clock    (clock),
      .load     (adv[0]),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .status   (status0),
      .ops      (ops0)
   );

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         status_ff[1] <= status0;
      end
      for (int i = 2; i < NUM_STAGES; i++) begin
         if (adv[i]) begin
            status_ff[i] <= status_ff[i-1];
         end
      end
   end

   for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
      rcsv_axis u_axis (
         .clock     (clock),
         .stage_adv (adv[NUM_STAGES-1:1]),
         .op        (ops0[a]),
         .vel       (vel[a])
      );
   end

   assign rsp_data.vel_x        = vel[0];
   assign rsp_data.vel_y        = vel[1];
   assign rsp_data.yaw_rate     = vel[2];
   assign rsp_data.drive_status = status_ff[NUM_STAGES-1];

endmodule

// ===== tb/tb_rc_stick_to_velocity_mapper.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rc_stick_to_velocity_mapper
// Drives remote-control frames through the velocity mapper under random
// valid/stall gaps. The register set is swept through several settings over
// the APB-style port. Each response is checked against a local predictor of
// the gear selection, deadband, scaling and clamping.
// ----------------------------------------------------------------------------
module tb_rc_stick_to_velocity_mapper;
   import rcsv_pkg::*;

   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 20;
   localparam int LONG_HOLD     = 80;
   localparam int BURST_FRAMES  = 40;
   localparam int PHASES        = 8;
   localparam int PHASE_FRAMES  = 228;
   localparam int STEADY_PHASE  = 3;
   localparam int BURST_PHASE   = 4;
   localparam int MAX_SHOWN     = 10;

   localparam int    VALID_LOW    = 900;
   localparam int    VALID_HIGH   = 2100;
   localparam int    CENTER       = 1500;
   localparam int    SPAN         = 500;
   localparam int    GEAR_FAST    = 1000;
   localparam int    GEAR_SLOW    = 2000;
   localparam longint SCALE_DIV   = 2048000;   // 500 * 4096
   localparam longint SCALE_ROUND = 1024000;

   typedef enum {SET_DIRECTED, SET_MAX, SET_MIN, SET_RANDOM} settings_kind_type;

   class velocity_scoreboard;
      logic [9:0]      deadband;
      logic [9:0]      switch_tol;
      logic [15:0]     enable_thr;
      logic [47:0]     fast_limits;
      logic [47:0]     mid_limits;
      logic [47:0]     slow_limits;
      logic [47:0]     axis_gains;
      logic [47:0]     hard_limits;
      rsp_payload_type expected_q[$];
      int              mismatch_total;

      function new();
         deadband       = 10'd10;
         switch_tol     = 10'd100;
         enable_thr     = 16'd1200;
         fast_limits    = '0;
         mid_limits     = '0;
         slow_limits    = '0;
         axis_gains     = '0;
         hard_limits    = '0;
         mismatch_total = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [63:0] value);
         case (idx)
            REG_DEADBAND:    deadband    = value[9:0];
            REG_SWITCH_TOL:  switch_tol  = value[9:0];
            REG_ENABLE_THR:  enable_thr  = value[15:0];
            REG_FAST_LIMITS: fast_limits = value[47:0];
            REG_MID_LIMITS:  mid_limits  = value[47:0];
            REG_SLOW_LIMITS: slow_limits = value[47:0];
            REG_AXIS_GAINS:  axis_gains  = value[47:0];
            REG_FINAL_LIMIT: hard_limits = value[47:0];
            default: ;
         endcase
      endfunction

      function int pending();
         return expected_q.size();
      endfunction

      function bit near_gear(logic [15:0] sw, int pos);
         int gap;
         gap = (int'(sw) > pos) ? int'(sw) - pos : pos - int'(sw);
         return gap <= int'(switch_tol);
      endfunction

      function logic [15:0] axis_velocity(logic [15:0] stick, logic signed [15:0] lim,
                                          logic [15:0] gain, logic signed [15:0] cap);
         longint offset;
         longint scaled;
         longint mag;
         bit     neg;
         offset = 0;
         if (int'(stick) >= VALID_LOW && int'(stick) <= VALID_HIGH) begin
            scaled = longint'(stick) - CENTER;
            mag = (scaled < 0) ? -scaled : scaled;
            if (mag > longint'(deadband)) offset = scaled;
         end
         if (offset > SPAN) offset = SPAN;
         if (offset < -SPAN) offset = -SPAN;
         scaled = offset * longint'(lim) * longint'(gain);
         neg = scaled < 0;
         mag = neg ? -scaled : scaled;
         mag = (mag + SCALE_ROUND) / SCALE_DIV;
         scaled = neg ? -mag : mag;
         // upper bound is tested first, even when a negative limit swaps the bounds
         if (scaled > longint'(lim)) scaled = longint'(lim);
         else if (scaled < -longint'(lim)) scaled = -longint'(lim);
         if (scaled > longint'(cap)) scaled = longint'(cap);
         else if (scaled < -longint'(cap)) scaled = -longint'(cap);
         scaled = -scaled;
         if (scaled > 32767) scaled = 32767;
         if (scaled < -32768) scaled = -32768;
         return scaled[15:0];
      endfunction

      function void note_frame(req_payload_type f);
         rsp_payload_type r;
         logic [47:0]     gear;
         r = '0;
         if (!f.link_valid) begin
            r.drive_status = STATUS_LINK_LOST;
         end else if (f.enable_knob > enable_thr) begin
            r.drive_status = STATUS_KNOB_LOCK;
         end else begin
            // fast gear wins when the switch is near both positions
            if (near_gear(f.gear_switch, GEAR_FAST)) gear = fast_limits;
            else if (near_gear(f.gear_switch, GEAR_SLOW)) gear = slow_limits;
            else gear = mid_limits;
            r.vel_x    = axis_velocity(f.forward_stick, gear[15:0], axis_gains[15:0],
                                       hard_limits[15:0]);
            r.vel_y    = axis_velocity(f.side_stick, gear[31:16], axis_gains[31:16],
                                       hard_limits[31:16]);
            r.yaw_rate = axis_velocity(f.turn_stick, gear[47:32], axis_gains[47:32],
                                       hard_limits[47:32]);
            r.drive_status = STATUS_DRIVING;
         end
         expected_q.push_back(r);
      endfunction

      function void flag(string msg);
         mismatch_total++;
         if (mismatch_total <= MAX_SHOWN) $display("%s", msg);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type exp;
         if (expected_q.size() == 0) begin
            flag($sformatf("unexpected response vx=%0d vy=%0d wz=%0d status=%0d",
                           got.vel_x, got.vel_y, got.yaw_rate, got.drive_status));
            return;
         end
         exp = expected_q.pop_front();
         if (got.vel_x !== exp.vel_x || got.vel_y !== exp.vel_y ||
             got.yaw_rate !== exp.yaw_rate || got.drive_status !== exp.drive_status)
            flag($sformatf("response mismatch: exp vx=%0d vy=%0d wz=%0d status=%0d, got vx=%0d vy=%0d wz=%0d status=%0d",
                           exp.vel_x, exp.vel_y, exp.yaw_rate, exp.drive_status,
                           got.vel_x, got.vel_y, got.yaw_rate, got.drive_status));
      endfunction
   endclass

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_stall;
   req_payload_type req_data = '0;
   logic            rsp_valid;
   logic            rsp_stall = 1'b0;
   rsp_payload_type rsp_data;
   logic            csr_psel = 1'b0;
   logic            csr_penable = 1'b0;
   logic            csr_pwrite = 1'b0;
   logic [5:0]      csr_paddr = '0;
   logic [63:0]     csr_pwdata = '0;
   logic [63:0]     csr_prdata;
   logic            csr_pready;

   velocity_scoreboard sb;
   bit                 steady_flow = 1'b0;
   bit                 long_hold_request = 1'b0;
   int                 cycle_count = 0;

   rc_stick_to_velocity_mapper dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Record each accepted transaction on both channels.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else if (!reset) begin
         if (req_valid && !req_stall) sb.note_frame(req_data);
         if (rsp_valid && !rsp_stall) sb.check_response(rsp_data);
      end
   end

   function automatic int gap_length();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
   endfunction

   function automatic int send_gap();
      if (steady_flow) return 0;
      return ($urandom_range(0, 9) < 6) ? 0 : gap_length();
   endfunction

   // Response side: alternate random runs of stall and flow, or hold off on request.
   initial begin : receiver
      int run_left;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            rsp_stall = 1'b1;
            repeat (LONG_HOLD - 1) @(negedge clock);
            run_left = 0;
         end else if (steady_flow) begin
            rsp_stall = 1'b0;
         end else begin
            if (run_left == 0) begin
               rsp_stall = !rsp_stall;
               run_left = rsp_stall ? gap_length() : $urandom_range(1, 12);
            end
            run_left--;
         end
      end
   end

   task automatic csr_write(reg_index_type idx, logic [63:0] value);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b1;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
   endtask

   task automatic send_frame(req_payload_type f);
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = f;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic sender_idle(int cycles);
      if (cycles > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (cycles - 1) @(negedge clock);
      end
   endtask

   // Hold the sender until every expected response is back.
   task automatic drain();
      sender_idle(1);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_limit();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         3: return 16'hFFFF;
         4, 5: return 16'($urandom_range(1, 16'h0800));
         6: return -16'($urandom_range(1, 16'h0800));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'h1000;
         2: return 16'hFFFF;
         3, 4: return 16'($urandom_range(0, 16'h3000));
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic apply_settings(settings_kind_type kind);
      logic [63:0] vals[8];
      case (kind)
         SET_DIRECTED: begin
            vals[REG_DEADBAND]    = 64'd10;
            vals[REG_SWITCH_TOL]  = 64'd100;
            vals[REG_ENABLE_THR]  = 64'd1200;
            vals[REG_FAST_LIMITS] = 64'h0100_0200_0400;
            vals[REG_MID_LIMITS]  = 64'h0080_0100_0200;
            vals[REG_SLOW_LIMITS] = 64'h8000_FF00_7FFF;
            vals[REG_AXIS_GAINS]  = 64'hFFFF_2000_1000;
            vals[REG_FINAL_LIMIT] = 64'h8000_0300_7FFF;
         end
         SET_MAX: begin
            vals[REG_DEADBAND]    = 64'd600;
            vals[REG_SWITCH_TOL]  = 64'd1000;
            vals[REG_ENABLE_THR]  = 64'd65535;
            vals[REG_FAST_LIMITS] = 64'h7FFF_7FFF_7FFF;
            vals[REG_MID_LIMITS]  = 64'h7FFF_7FFF_7FFF;
            vals[REG_SLOW_LIMITS] = 64'h7FFF_7FFF_7FFF;
            vals[REG_AXIS_GAINS]  = 64'hFFFF_FFFF_FFFF;
            vals[REG_FINAL_LIMIT] = 64'h7FFF_7FFF_7FFF;
         end
         SET_MIN: begin
            foreach (vals[i]) vals[i] = '0;
            vals[REG_MID_LIMITS]  = 64'h0400_0400_0400;
            vals[REG_AXIS_GAINS]  = 64'h1000_1000_1000;
            vals[REG_FINAL_LIMIT] = 64'h7FFF_7FFF_7FFF;
         end
         default: begin
            vals[REG_DEADBAND]    = 64'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                                   : $urandom_range(0, 60));
            vals[REG_SWITCH_TOL]  = 64'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                                   : $urandom_range(0, 300));
            vals[REG_ENABLE_THR]  = 64'($urandom_range(0, 65535));
            vals[REG_FAST_LIMITS] = 64'({pick_limit(), pick_limit(), pick_limit()});
            vals[REG_MID_LIMITS]  = 64'({pick_limit(), pick_limit(), pick_limit()});
            vals[REG_SLOW_LIMITS] = 64'({pick_limit(), pick_limit(), pick_limit()});
            vals[REG_AXIS_GAINS]  = 64'({pick_gain(), pick_gain(), pick_gain()});
            vals[REG_FINAL_LIMIT] = 64'({pick_limit(), pick_limit(), pick_limit()});
         end
      endcase
      for (int i = REG_DEADBAND; i <= REG_FINAL_LIMIT; i++)
         csr_write(reg_index_type'(i), vals[i]);
   endtask

   function automatic req_payload_type frame_of(logic lv, int fwd, int side, int turn,
                                                int sw, int knob);
      req_payload_type f;
      f.link_valid    = lv;
      f.forward_stick = 16'(fwd);
      f.side_stick    = 16'(side);
      f.turn_stick    = 16'(turn);
      f.gear_switch   = 16'(sw);
      f.enable_knob   = 16'(knob);
      return f;
   endfunction

   function automatic logic [15:0] random_stick();
      int db;
      db = int'(sb.deadband) + $urandom_range(0, 2);
      case ($urandom_range(0, 11))
         0, 1, 2, 3, 4, 5: return 16'($urandom_range(VALID_LOW, VALID_HIGH));
         6, 7: return 16'($urandom_range(0, 1) ? CENTER + db : CENTER - db);
         8: begin
            case ($urandom_range(0, 5))
               0: return 16'(VALID_LOW - 1);
               1: return 16'(VALID_LOW);
               2: return 16'(VALID_HIGH);
               3: return 16'(VALID_HIGH + 1);
               4: return 16'(CENTER - SPAN);
               default: return 16'(CENTER + SPAN);
            endcase
         end
         9: return 16'($urandom_range(0, VALID_LOW - 1));
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] random_switch();
      int t;
      int v;
      t = int'(sb.switch_tol) + 2;
      case ($urandom_range(0, 6))
         0, 1: v = GEAR_FAST + int'($urandom_range(0, 2 * t)) - t;
         2, 3: v = GEAR_SLOW + int'($urandom_range(0, 2 * t)) - t;
         4, 5: v = $urandom_range(0, 3000);
         default: v = $urandom_range(0, 65535);
      endcase
      if (v < 0) v = 0;
      return 16'(v);
   endfunction

   function automatic logic [15:0] random_knob();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, int'(sb.enable_thr)));
         6: return sb.enable_thr;
         7: return sb.enable_thr + 16'd1;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic req_payload_type random_frame();
      req_payload_type f;
      f.link_valid    = $urandom_range(0, 19) != 0;
      f.forward_stick = random_stick();
      f.side_stick    = random_stick();
      f.turn_stick    = random_stick();
      f.gear_switch   = random_switch();
      f.enable_knob   = random_knob();
      return f;
   endfunction

   task automatic send_directed(req_payload_type f);
      send_frame(f);
      sender_idle(send_gap());
   endtask

   initial begin : stimulus
      sb = new();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      apply_settings(SET_DIRECTED);
      send_directed(frame_of(1'b0, 65535, 65535, 65535, 65535, 65535));
      send_directed(frame_of(1'b0, 0, 0, 0, 0, 0));
      send_directed(frame_of(1'b1, 1500, 1500, 1500, 1000, 1201));
      send_directed(frame_of(1'b1, 1500, 1500, 1500, 2000, 65535));
      send_directed(frame_of(1'b1, 2000, 1000, 1500, 1000, 1200));
      send_directed(frame_of(1'b1, 0, 65535, 899, 1000, 0));
      send_directed(frame_of(1'b1, 900, 2100, 2101, 1000, 0));
      send_directed(frame_of(1'b1, 1510, 1490, 1511, 1000, 0));
      send_directed(frame_of(1'b1, 1489, 1001, 1999, 900, 0));
      send_directed(frame_of(1'b1, 1750, 1250, 1700, 1100, 0));
      send_directed(frame_of(1'b1, 1750, 1250, 1700, 1101, 0));
      send_directed(frame_of(1'b1, 1750, 1250, 1700, 1500, 0));
      send_directed(frame_of(1'b1, 2000, 1000, 2100, 1900, 0));
      send_directed(frame_of(1'b1, 1000, 2000, 900, 2100, 0));
      send_directed(frame_of(1'b1, 1800, 1200, 1600, 2101, 0));
      send_directed(frame_of(1'b1, 1800, 1200, 1600, 0, 0));
      send_directed(frame_of(1'b1, 1800, 1200, 1600, 65535, 0));
      send_directed(frame_of(1'b1, 1600, 1400, 1000, 1000, 1000));
      drain();

      // wide tolerance: switch is near both gear positions at once
      csr_write(REG_SWITCH_TOL, 64'd600);
      send_directed(frame_of(1'b1, 1700, 1300, 1800, 1500, 0));
      send_directed(frame_of(1'b1, 1200, 1800, 2000, 1450, 100));
      drain();

      for (int p = 0; p < PHASES; p++) begin
         drain();
         case (p)
            0: apply_settings(SET_MAX);
            1: apply_settings(SET_MIN);
            default: apply_settings(SET_RANDOM);
         endcase
         steady_flow = (p == STEADY_PHASE);
         if (p == BURST_PHASE) begin
            // fill the pipeline against a held-off receiver
            long_hold_request = 1'b1;
            for (int n = 0; n < BURST_FRAMES; n++) send_frame(random_frame());
            drain();
         end
         for (int n = 0; n < PHASE_FRAMES; n++) begin
            send_frame(random_frame());
            sender_idle(send_gap());
         end
         steady_flow = 1'b0;
      end
      drain();

      if (sb.pending() != 0) sb.flag($sformatf("%0d responses missing", sb.pending()));
      if (sb.mismatch_total == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
